[hw/rtl/bfs_pkg.sv]
// ----------------------------------------------------------------------------
// bfs_pkg: shared types and constants of the Bloom filter string set
// Holds the hash constants, the bit store row geometry, the controller state
// type and the command and status structs between controller and datapath.
// ----------------------------------------------------------------------------
package bfs_pkg;

    // FNV-1a constants; only the low address bits of each lane are used.
    localparam logic [31:0] OFFSET_BASIS = 32'h811C9DC5;
    localparam logic [31:0] FNV_PRIME    = 32'h01000193;

    // The bit store is kept as rows of 64 bits.
    localparam int unsigned ROW_BITS = 6;
    localparam int unsigned ROW_W    = 1 << ROW_BITS;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WRITE,
        ST_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_ready;
        logic clear_en;
        logic rd_en;
        logic wr_en;
        logic finish;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_end;
        logic clear_last;
        logic lane_last;
        logic out_free;
    } t_dp_sts;

endpackage

[hw/rtl/bfs_if.sv]
// ----------------------------------------------------------------------------
// bfs_if: channel interfaces of the Bloom filter string set
// bfs_in_if carries string bytes with their command; bfs_out_if carries the
// result of an add or a check.
// ----------------------------------------------------------------------------
interface bfs_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;

    modport source (output valid, kind, data_byte, byte_valid, last, input ready);
    modport sink   (input valid, kind, data_byte, byte_valid, last, output ready);
endinterface

interface bfs_out_if;
    logic valid;
    logic ready;
    logic present;
    logic from_check;

    modport source (output valid, present, from_check, input ready);
    modport sink   (input valid, present, from_check, output ready);
endinterface

[hw/rtl/bfs_ctrl.sv]
// ----------------------------------------------------------------------------
// bfs_ctrl: controller of the Bloom filter string set
// Sequences the clearing pass after reset, byte intake, the per-lane
// read-modify-write of the bit store at the end of a string, and the
// hand-over of the result to the output register.
// ----------------------------------------------------------------------------
module bfs_ctrl
    import bfs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_sts.clear_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_sts.in_end) n_state = ST_READ;
            end
            ST_READ: begin
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                n_state = i_sts.lane_last ? ST_FINISH : ST_READ;
            end
            ST_FINISH: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Command outputs.
    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_CLEAR:  o_cmd.clear_en = 1'b1;
            ST_IDLE:   o_cmd.in_ready = 1'b1;
            ST_READ:   o_cmd.rd_en    = 1'b1;
            ST_WRITE:  o_cmd.wr_en    = 1'b1;
            ST_FINISH: o_cmd.finish   = i_sts.out_free;
            default:   o_cmd = '0;
        endcase
    end

    // Every row read is followed by its write step.
    a_read_then_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_en |=> o_cmd.wr_en)
        else $error("bfs_ctrl: read not followed by write step");

    // A result is only handed over when the output register can take it.
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> i_sts.out_free)
        else $error("bfs_ctrl: finish while output register is full");

endmodule

[hw/rtl/bfs_dp.sv]
// ----------------------------------------------------------------------------
// bfs_dp: datapath of the Bloom filter string set
// Holds the FNV-1a hash lanes, the bit store memory with its clear counter,
// the lane counter for end-of-string accesses and the output register.
// ----------------------------------------------------------------------------
module bfs_dp
    import bfs_pkg::*;
#(
    parameter int unsigned FILTER_BITS = 1048576,
    parameter int unsigned HASH_COUNT  = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    output t_dp_sts    o_sts,
    bfs_in_if.sink     i_in,
    bfs_out_if.source  o_res
);

    localparam int unsigned ADDR_W     = $clog2(FILTER_BITS);
    localparam int unsigned ROW_ADDR_W = ADDR_W - ROW_BITS;
    localparam int unsigned ROWS       = FILTER_BITS / ROW_W;
    localparam int unsigned LANE_W     = (HASH_COUNT > 1) ? $clog2(HASH_COUNT) : 1;

    logic [ADDR_W-1:0]     r_lanes [HASH_COUNT];
    logic [ADDR_W-1:0]     w_seed  [HASH_COUNT];
    logic [ADDR_W-1:0]     w_hash  [HASH_COUNT];
    logic [LANE_W-1:0]     r_lane;
    logic [ROW_ADDR_W-1:0] r_clr;
    logic [ROW_W-1:0]      r_mem [ROWS];
    logic [ROW_W-1:0]      r_rd_data;
    logic                  r_kind;
    logic                  r_present;
    logic                  r_out_valid;
    logic                  r_out_present;
    logic                  r_out_check;

    logic                  w_in_fire;
    logic [ADDR_W-1:0]     w_addr;
    logic [ROW_ADDR_W-1:0] w_row;
    logic [ROW_BITS-1:0]   w_bit;
    logic                  w_we;
    logic [ROW_ADDR_W-1:0] w_wa;
    logic [ROW_W-1:0]      w_wd;

    assign w_in_fire = i_in.valid && i_cmd.in_ready;
    assign i_in.ready = i_cmd.in_ready;

    // Lane seeds and one FNV-1a step per lane, kept to the address width.
    for (genvar g = 0; g < HASH_COUNT; g++) begin : g_lane
        logic [ADDR_W-1:0] w_mix;
        assign w_seed[g] = ADDR_W'(OFFSET_BASIS ^ 32'(g));
        assign w_mix     = r_lanes[g] ^ ADDR_W'(i_in.data_byte);
        assign w_hash[g] = ADDR_W'(w_mix * ADDR_W'(FNV_PRIME));
    end

    // Hash lanes: reseeded at reset and after each string.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.finish) begin
            for (int i = 0; i < HASH_COUNT; i++) r_lanes[i] <= w_seed[i];
        end else if (w_in_fire && i_in.byte_valid) begin
            for (int i = 0; i < HASH_COUNT; i++) r_lanes[i] <= w_hash[i];
        end
    end

    // Command and accumulator captured at the end of a string.
    always_ff @(posedge i_clk) begin
        if (w_in_fire && i_in.last) begin
            r_kind    <= i_in.kind;
            r_present <= 1'b1;
        end else if (i_cmd.wr_en) begin
            r_present <= r_present & r_rd_data[w_bit];
        end
    end

    // Lane counter for the end-of-string accesses.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.finish) begin
            r_lane <= '0;
        end else if (i_cmd.wr_en && !o_sts.lane_last) begin
            r_lane <= r_lane + 1'b1;
        end
    end

    // Clear counter walks every row once after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clear_en) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    // Address of the current lane split into row and bit.
    assign w_addr = r_lanes[r_lane];
    assign w_row  = w_addr[ADDR_W-1:ROW_BITS];
    assign w_bit  = w_addr[ROW_BITS-1:0];

    // Write port: clearing rows, or setting one bit for an add.
    always_comb begin
        w_we = i_cmd.clear_en || (i_cmd.wr_en && !r_kind);
        w_wa = i_cmd.clear_en ? r_clr : w_row;
        w_wd = i_cmd.clear_en ? '0 : (r_rd_data | (ROW_W'(1) << w_bit));
    end

    // Bit store memory with registered read data.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[w_row];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_present <= r_kind & r_present;
            r_out_check   <= r_kind;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.present    = r_out_present;
    assign o_res.from_check = r_out_check;

    // Status to the controller.
    always_comb begin
        o_sts.in_end     = i_in.valid && i_in.last;
        o_sts.clear_last = (r_clr == ROW_ADDR_W'(ROWS - 1));
        o_sts.lane_last  = (r_lane == LANE_W'(HASH_COUNT - 1));
        o_sts.out_free   = !r_out_valid || o_res.ready;
    end

    // No transaction is taken while the bit store is being cleared.
    a_no_input_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |-> !i_cmd.clear_en)
        else $error("bfs_dp: input taken during clearing pass");

    // Finishing a string leaves the lane counter at the first lane.
    a_lane_rewind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> r_lane == '0)
        else $error("bfs_dp: lane counter not rewound after finish");

endmodule

[hw/rtl/bloom_filter_string_set.sv]
// ----------------------------------------------------------------------------
// bloom_filter_string_set: Bloom filter over byte strings, FNV-1a hashing
// Adds strings to a bit store or checks them for membership.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one string byte per transaction with kind, byte_valid and
//   last. Bytes of a string are taken one per cycle. An item with last set
//   ends the string (byte_valid low on it ends an empty string) and selects
//   add (kind 0) or check (kind 1).
//   o_res carries one transaction per string: present and from_check.
//   At the end of a string each of the HASH_COUNT lanes does a row read and a
//   write step on the single bit store memory before the result lands in the
//   output register; the next string's bytes are then taken right away.
//   After reset the bit store is cleared one 64-bit row per cycle, through all
//   FILTER_BITS / 64 rows, during which i_in.ready stays low.
//   When the receiver stalls, a finished result waits in the output
//   register; bytes keep flowing in, and the following string end waits only
//   until that result has been taken.
// ----------------------------------------------------------------------------
module bloom_filter_string_set
    import bfs_pkg::*;
#(
    parameter int unsigned FILTER_BITS = 1048576,
    parameter int unsigned HASH_COUNT  = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bfs_in_if.sink    i_in,
    bfs_out_if.source o_res
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    bfs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    bfs_dp #(
        .FILTER_BITS (FILTER_BITS),
        .HASH_COUNT  (HASH_COUNT)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .i_in    (i_in),
        .o_res   (o_res)
    );

endmodule
